@@ rtl/tccw_pkg.sv @@
// ----------------------------------------------------------------------------
// tccw_pkg: shared definitions for the text console cell writer
// Screen geometry, field widths, controller states and the command/status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package tccw_pkg;

  // screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;

  // internal widths
  localparam int ADDR_W = $clog2(CELL_COUNT);       // memory index
  localparam int CNT_W  = $clog2(CELL_COUNT + 1);   // sweep counter, reaches CELL_COUNT
  localparam int ROW_W  = $clog2(ROWS + 1);         // row may equal ROWS (scroll pending)
  localparam int COL_W  = $clog2(COLUMNS);

  // fixed field widths
  localparam int CHAR_W   = 8;
  localparam int COLOR_W  = 8;
  localparam int RADDR_W  = 11;
  localparam int CELL_W   = 16;
  localparam int OROW_W   = 5;
  localparam int OCOL_W   = 7;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  // codes
  localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
  localparam logic [CELL_W-1:0]  BLANK_CELL   = 16'h0720;
  localparam logic [COLOR_W-1:0] COLOR_RESET  = 8'd7;
  localparam logic               FUNC_PUT     = 1'b0;
  localparam logic               FUNC_READ    = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_SCROLL,
    ST_PUT,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;        // latch the input item
    logic clear_step;    // write one blank cell of the power-up sweep
    logic read_issue;    // read the addressed cell
    logic scroll_start;  // arm the row copy sweep
    logic scroll_step;   // one copy sweep cycle
    logic put_do;        // apply the put to screen and cursor
    logic emit;          // load the output register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic item_is_read;
    logic scroll_pending;
    logic scroll_done;
    logic out_free;
  } dp_status_t;

endpackage

@@ rtl/tccw_ctrl.sv @@
// ----------------------------------------------------------------------------
// tccw_ctrl: controller state machine
// Sequences the power-up clear, item dispatch, scroll copy, put and result.
// ----------------------------------------------------------------------------
module tccw_ctrl
  import tccw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (status.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (status.item_is_read) begin
          state_next = ST_EMIT;
        end else if (status.scroll_pending) begin
          state_next = ST_SCROLL;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_SCROLL: begin
        if (status.scroll_done) state_next = ST_PUT;
      end
      ST_PUT: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
      end
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_DISPATCH: begin
        if (status.item_is_read) begin
          cmd.read_issue = 1'b1;
        end else if (status.scroll_pending) begin
          cmd.scroll_start = 1'b1;
        end else begin
          cmd.put_do = 1'b1;
        end
      end
      ST_SCROLL: begin
        cmd.scroll_step = 1'b1;
      end
      ST_PUT: begin
        cmd.put_do = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ rtl/tccw_datapath.sv @@
// ----------------------------------------------------------------------------
// tccw_datapath: screen memory, cursor, colour register and output register
// Holds the cell memory with one write and one registered read port, the
// sweep counter shared by the clear and the scroll copy, and the result.
// ----------------------------------------------------------------------------
module tccw_datapath
  import tccw_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  ctrl_cmd_t              cmd,
  output dp_status_t             status,
  // input item fields
  input  logic                   in_func,
  input  logic [CHAR_W-1:0]      in_char,
  input  logic [RADDR_W-1:0]     in_addr,
  // colour register write
  input  logic                   color_we,
  input  logic [COLOR_W-1:0]     color_data,
  // result
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [CELL_W-1:0]      out_read_data,
  output logic [OROW_W-1:0]      out_row,
  output logic [OCOL_W-1:0]      out_col,
  output logic                   out_scroll
);

  logic [CELL_W-1:0]  mem [CELL_COUNT];
  logic [CELL_W-1:0]  mem_q;

  logic [COLOR_W-1:0] text_color;
  logic [ROW_W-1:0]   cur_row;
  logic [COL_W-1:0]   cur_col;

  logic               item_func;
  logic [CHAR_W-1:0]  item_char;
  logic [RADDR_W-1:0] item_addr;
  logic               item_in_range;
  logic               scrolled;

  logic [CNT_W-1:0]   scan_cnt;
  logic               copy_pending;
  logic [ADDR_W-1:0]  copy_dst;

  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [CELL_W-1:0]  wr_data;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ADDR_W-1:0]  put_idx;
  logic               scan_live;
  logic               is_newline;

  assign scan_live  = scan_cnt < CNT_W'(CELL_COUNT);
  assign is_newline = item_char == NEWLINE_CODE;
  assign put_idx    = ADDR_W'(cur_row) * ADDR_W'(COLUMNS) + ADDR_W'(cur_col);

  // status to controller
  always_comb begin
    status.clear_last     = scan_cnt == CNT_W'(CELL_COUNT - 1);
    status.item_is_read   = item_func == FUNC_READ;
    status.scroll_pending = cur_row == ROW_W'(ROWS);
    status.scroll_done    = !scan_live && !copy_pending;
    status.out_free       = !out_valid || out_ready;
  end

  // memory write port select
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = BLANK_CELL;
    if (cmd.clear_step) begin
      wr_en   = 1'b1;
      wr_addr = scan_cnt[ADDR_W-1:0];
    end else if (copy_pending) begin
      wr_en   = 1'b1;
      wr_addr = copy_dst;
      wr_data = mem_q;
    end else if (cmd.put_do && !is_newline) begin
      wr_en   = 1'b1;
      wr_addr = put_idx;
      wr_data = {text_color, item_char};
    end
  end

  // memory read port select
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (cmd.scroll_step && scan_live) begin
      rd_en   = 1'b1;
      rd_addr = scan_cnt[ADDR_W-1:0];
    end else if (cmd.read_issue && item_in_range) begin
      rd_en   = 1'b1;
      rd_addr = ADDR_W'(item_addr);
    end
  end

  // screen memory
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) mem_q <= mem[rd_addr];
  end

  // sweep counter and copy pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt     <= '0;
      copy_pending <= 1'b0;
    end else if (cmd.clear_step) begin
      scan_cnt <= scan_cnt + 1'b1;
    end else if (cmd.scroll_start) begin
      scan_cnt     <= CNT_W'(COLUMNS);
      copy_pending <= 1'b0;
    end else if (cmd.scroll_step) begin
      copy_pending <= scan_live;
      if (scan_live) scan_cnt <= scan_cnt + 1'b1;
    end else begin
      copy_pending <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    copy_dst <= ADDR_W'(scan_cnt - CNT_W'(COLUMNS));
  end

  // colour register
  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= COLOR_RESET;
    end else if (color_we) begin
      text_color <= color_data;
    end
  end

  // item latch
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_func     <= in_func;
      item_char     <= in_char;
      item_addr     <= in_addr;
      item_in_range <= 32'(in_addr) < 32'(CELL_COUNT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scrolled <= 1'b0;
    end else if (cmd.accept) begin
      scrolled <= 1'b0;
    end else if (cmd.scroll_start) begin
      scrolled <= 1'b1;
    end
  end

  // cursor
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row <= '0;
      cur_col <= '0;
    end else if (cmd.scroll_start) begin
      cur_row <= ROW_W'(ROWS - 1);
    end else if (cmd.put_do) begin
      if (is_newline) begin
        cur_row <= cur_row + 1'b1;
        cur_col <= '0;
      end else if (cur_col == COL_W'(COLUMNS - 1)) begin
        cur_row <= cur_row + 1'b1;
        cur_col <= '0;
      end else begin
        cur_col <= cur_col + 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_read_data <= (item_func == FUNC_READ && item_in_range) ? mem_q : '0;
      out_row       <= OROW_W'(cur_row);
      out_col       <= OCOL_W'(cur_col);
      out_scroll    <= scrolled;
    end
  end

endmodule

@@ rtl/text_console_cell_writer.sv @@
// ----------------------------------------------------------------------------
// text_console_cell_writer: text screen cell writer with cursor and scroll
// Keeps a screen of character/colour cells and a cursor; puts characters,
// handles newline, end-of-line wrap and deferred scroll, and reads cells.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  s_*      in         s_tvalid / s_tready  item: func, char_code, read_address
//  m_*      out        m_tvalid / m_tready  result: read_data, cursor, did_scroll
//  cfg_*    in         cfg_valid/cfg_ready  text_color
//
//  a read or a plain put steps through accept, dispatch and result
//  register load before the next item is accepted; m_tvalid rises
//  with that load; a put that finds a scroll pending first moves every
//  row but the top up by one through the single memory port pair
//  after reset a clearing pass writes every cell blank with s_tready
//  low; cfg writes are taken at all times
//  a new item is accepted while the previous result waits in m_tdata
//
module text_console_cell_writer
  import tccw_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // input items
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] char_code, [18:8] read_address
  input  logic                   s_tuser,   // [0] func
  // results
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // [15:0] read_data, [20:16] cursor_row_out,
                                            // [27:21] cursor_column_out, [28] did_scroll
  // colour register
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [COLOR_W-1:0]     cfg_data
);

  ctrl_cmd_t          cmd;
  dp_status_t         status;
  logic [CELL_W-1:0]  out_read_data;
  logic [OROW_W-1:0]  out_row;
  logic [OCOL_W-1:0]  out_col;
  logic               out_scroll;

  assign cfg_ready = 1'b1;

  tccw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  tccw_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .in_func       (s_tuser),
    .in_char       (s_tdata[CHAR_W-1:0]),
    .in_addr       (s_tdata[CHAR_W +: RADDR_W]),
    .color_we      (cfg_valid && cfg_ready),
    .color_data    (cfg_data),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_read_data (out_read_data),
    .out_row       (out_row),
    .out_col       (out_col),
    .out_scroll    (out_scroll)
  );

  // pack result fields, zero fill to whole bytes
  assign m_tdata = {3'b000, out_scroll, out_col, out_row, out_read_data};

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for text_console_cell_writer
// Drives put and read items into the stream port under random idling on both
// sides and changes the colour register between phases. A shadow screen with
// its own cursor predicts every result, and each returned item is compared
// field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import tccw_pkg::*;

  localparam int unsigned RUN_LIMIT    = 6_000_000;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 100;
  localparam int unsigned REPORT_LIMIT = 20;

  typedef struct packed {
    logic [CELL_W-1:0] read_data;
    logic [OROW_W-1:0] row;
    logic [OCOL_W-1:0] column;
    logic              scrolled;
  } console_result_t;

  // shadow of the screen, the cursor and the colour register
  class screen_model;
    logic [CELL_W-1:0]  screen [CELL_COUNT];
    int unsigned        row;
    int unsigned        column;
    logic [COLOR_W-1:0] color;
    console_result_t    results_due [$];
    int unsigned errors, puts, newlines, reads, reads_outside, scrolls, wraps, colors;

    function new();
      foreach (screen[i]) screen[i] = BLANK_CELL;
      row    = 0;
      column = 0;
      color  = COLOR_RESET;
    endfunction

    function void set_color(logic [COLOR_W-1:0] value);
      color = value;
      colors++;
    endfunction

    function int unsigned pending();
      return results_due.size();
    endfunction

    // work out the result of one accepted item and update the screen
    function void apply_item(logic fn, logic [CHAR_W-1:0] ch, logic [RADDR_W-1:0] addr);
      console_result_t want;
      want = '0;
      if (fn == FUNC_READ) begin
        reads++;
        if (addr < CELL_COUNT) want.read_data = screen[addr];
        else reads_outside++;
      end else begin
        puts++;
        // a pending scroll is carried out before the put itself
        if (row >= ROWS) begin
          for (int i = 0; i < CELL_COUNT - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
          row = ROWS - 1;
          want.scrolled = 1'b1;
          scrolls++;
        end
        if (ch == NEWLINE_CODE) begin
          newlines++;
          row++;
          column = 0;
        end else begin
          screen[row * COLUMNS + column] = {color, ch};
          column++;
          if (column >= COLUMNS) begin
            column = 0;
            row++;
            wraps++;
          end
        end
      end
      want.row    = row[OROW_W-1:0];
      want.column = column[OCOL_W-1:0];
      results_due.push_back(want);
    endfunction

    function void compare(string name, logic [CELL_W-1:0] want, logic [CELL_W-1:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] word);
      console_result_t want;
      if (results_due.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: unexpected item, expected none actual %h", $time, word);
        return;
      end
      want = results_due.pop_front();
      compare("read_data", want.read_data, word[CELL_W-1:0]);
      compare("cursor_row_out", want.row, word[CELL_W +: OROW_W]);
      compare("cursor_column_out", want.column, word[CELL_W + OROW_W +: OCOL_W]);
      compare("did_scroll", want.scrolled, word[CELL_W + OROW_W + OCOL_W]);
    endfunction
  endclass

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;   // [7:0] char_code, [18:8] read_address
  logic                   s_tuser   = 1'b0; // [0] func
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;          // [15:0] read_data, [20:16] cursor_row_out,
                                            // [27:21] cursor_column_out, [28] did_scroll
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [COLOR_W-1:0]     cfg_data  = '0;

  bit          quiet_phase = 1'b0;
  int unsigned cycles      = 0;
  screen_model shadow      = new();

  text_console_cell_writer u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    while (cycles < RUN_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("text_console_cell_writer verification failed");
    $finish;
  end

  function automatic int unsigned idle_cycles();
    return quiet_phase ? 0 : $urandom_range(0, 7);
  endfunction

  // handshakes seen at each edge
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) shadow.set_color(cfg_data);
      if (s_tvalid && s_tready)
        shadow.apply_item(s_tuser, s_tdata[CHAR_W-1:0], s_tdata[CHAR_W +: RADDR_W]);
      if (m_tvalid && m_tready) shadow.check_result(m_tdata);
    end
  end

  // result side stalls
  initial begin
    int unsigned stall;
    forever begin
      stall = idle_cycles();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // one item, held until accepted
  task automatic send_item(input logic fn, input logic [CHAR_W-1:0] ch,
                           input logic [RADDR_W-1:0] addr);
    int unsigned gap;
    gap = idle_cycles();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= fn;
    s_tdata  <= IN_TDATA_W'({addr, ch});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // stop sending, let every result come back, then load a new colour
  task automatic drain_then_color(input logic [COLOR_W-1:0] value);
    s_tvalid <= 1'b0;
    // let the monitor note the last accepted item before polling
    @(posedge clk);
    while (shadow.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly puts; reads favor the bottom rows where scrolls land
  task automatic random_item(input int unsigned newline_pct);
    logic [CHAR_W-1:0]  ch;
    logic [RADDR_W-1:0] addr;
    if ($urandom_range(0, 99) < 25) begin
      case ($urandom_range(0, 3))
        0:       addr = RADDR_W'($urandom_range(0, (1 << RADDR_W) - 1));
        1:       addr = RADDR_W'($urandom_range(CELL_COUNT - 2 * COLUMNS, CELL_COUNT - 1));
        default: addr = RADDR_W'($urandom_range(0, CELL_COUNT - 1));
      endcase
      send_item(FUNC_READ, CHAR_W'($urandom_range(0, 255)), addr);
    end else begin
      if ($urandom_range(0, 99) < newline_pct) ch = NEWLINE_CODE;
      else ch = CHAR_W'($urandom_range(0, 255));
      send_item(FUNC_PUT, ch, RADDR_W'($urandom_range(0, (1 << RADDR_W) - 1)));
    end
  endtask

  // stimulus
  initial begin
    logic [COLOR_W-1:0] color;
    int unsigned        newline_pct;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // blank screen after reset, including reads past the last cell
    send_item(FUNC_READ, 8'h00, 11'd0);
    send_item(FUNC_READ, 8'hFF, 11'd1999);
    send_item(FUNC_READ, 8'h00, 11'd2000);
    send_item(FUNC_READ, 8'hFF, 11'd2047);
    send_item(FUNC_READ, 8'h00, 11'd1024);
    // character extremes with the reset colour, then newlines
    send_item(FUNC_PUT, 8'h00, 11'd2047);
    send_item(FUNC_PUT, 8'hFF, 11'd0);
    send_item(FUNC_PUT, 8'h41, 11'd0);
    send_item(FUNC_PUT, NEWLINE_CODE, 11'd0);
    send_item(FUNC_PUT, NEWLINE_CODE, 11'd0);
    send_item(FUNC_PUT, 8'h42, 11'd0);
    send_item(FUNC_READ, 8'h00, 11'd0);
    send_item(FUNC_READ, 8'h00, 11'd1);
    send_item(FUNC_READ, 8'h00, 11'd2);
    send_item(FUNC_READ, 8'h00, 11'd160);
    send_item(FUNC_READ, 8'h00, 11'd80);
    // full colour byte
    drain_then_color(8'hFF);
    send_item(FUNC_PUT, 8'h20, 11'd0);
    send_item(FUNC_READ, 8'h00, 11'd161);

    // random phases: newline density alternates between dense and sparse,
    // so both runs of scrolls at the bottom and end-of-line wraps occur
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       begin color = 8'h00; newline_pct = 15; end
        1:       begin color = 8'hFF; newline_pct = 2;  end
        2:       begin color = COLOR_W'($urandom_range(0, 255)); newline_pct = 30; end
        3:       begin color = 8'h1F; newline_pct = 1;  end
        4:       begin color = COLOR_W'($urandom_range(0, 255)); newline_pct = 10; end
        5:       begin color = 8'hF0; newline_pct = 3;  end
        6:       begin color = 8'h07; newline_pct = 20; end
        default: begin color = COLOR_W'($urandom_range(0, 255)); newline_pct = 2; end
      endcase
      quiet_phase = (phase == 3 || phase == 6);
      drain_then_color(color);
      repeat (PHASE_ITEMS) random_item(newline_pct);
    end
    quiet_phase = 1'b0;

    // wind down
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (shadow.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (shadow.pending() != 0) shadow.errors++;

    $display("covered %0d puts (%0d newlines, %0d wraps, %0d scrolls), %0d reads (%0d past end)",
             shadow.puts, shadow.newlines, shadow.wraps, shadow.scrolls,
             shadow.reads, shadow.reads_outside);
    $display("%0d colour settings, %0d mismatches", shadow.colors, shadow.errors);
    if (shadow.errors == 0) begin
      $display("text_console_cell_writer verification clean");
    end else begin
      $display("text_console_cell_writer verification failed");
    end
    $finish;
  end

endmodule
